// ===== src/gnms_pkg.sv =====
// Shared types, widths and codes for the greedy per-class NMS block.
// Used by gnms_store, gnms_iou and greedy_nms_per_class; no dependencies.
`timescale 1ns / 1ps

package gnms_pkg;

   // Field widths fixed by the box and result formats.
   localparam int COORD_W   = 16;
   localparam int AREA_W    = 32;
   localparam int THR_W     = 17;
   localparam int VERDICT_W = 2;
   localparam int SLOT_W    = 7;

   // Overlap arithmetic widths.
   localparam int SUM_W = AREA_W + 1;
   localparam int MUL_W = THR_W + SUM_W;
   localparam int FRAC_W = 16;

   // Default sizes of the kept list and of the input cap.
   localparam int MAX_KEEP_DEF   = 100;
   localparam int MAX_INPUTS_DEF = 200;

   // Overlap threshold after reset, Q1.16.
   localparam logic [THR_W-1:0] IOU_RESET = 17'd29491;

   // Verdict codes.
   localparam logic [VERDICT_W-1:0] VERDICT_KEPT = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_SUPP = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_FULL = 2'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_CAP  = 2'd3;

   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] bottom;
   } box_type;

   typedef struct packed {
      box_type            box;
      logic [AREA_W-1:0]  area;
   } entry_type;

   // Status of the overlap unit as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic hit;
   } iou_stat_type;

   // Extent of an interval, zero when it is empty.
   function automatic logic [COORD_W-1:0] span(input logic [COORD_W-1:0] lo,
                                               input logic [COORD_W-1:0] hi);
      span = (hi > lo) ? (hi - lo) : '0;
   endfunction

endpackage

// ===== src/gnms_store.sv =====
// Kept-box memory: one write port and one registered read port.
// Depends on gnms_pkg for the entry type.
`timescale 1ns / 1ps

module gnms_store #(
   parameter int DEPTH = gnms_pkg::MAX_KEEP_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  gnms_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output logic                rd_valid,
   output gnms_pkg::entry_type rd_data
);
   import gnms_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;
   logic      rd_valid_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Read data valid flag follows the read enable in the next cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_data  = rd_data_ff;

endmodule

// ===== src/gnms_iou.sv =====
// Pipelined overlap test of one kept box against the candidate box per cycle.
// Depends on gnms_pkg for box types, widths and the span function.
`timescale 1ns / 1ps

module gnms_iou (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  gnms_pkg::entry_type      kept,
   input  gnms_pkg::box_type        cand,
   input  logic [gnms_pkg::AREA_W-1:0] cand_area,
   input  logic [gnms_pkg::THR_W-1:0]  thr,
   output gnms_pkg::iou_stat_type   stat
);
   import gnms_pkg::*;

   // Stage 1: intersection extents.
   logic               v1_ff, pos1_ff;
   logic [COORD_W-1:0] iw1_ff, ih1_ff;
   logic [AREA_W-1:0]  ak1_ff;
   // Stage 2: intersection area and area sum.
   logic               v2_ff, pos2_ff;
   logic [AREA_W-1:0]  inter2_ff;
   logic [SUM_W-1:0]   sum2_ff;
   // Stage 3: union.
   logic               v3_ff, ok3_ff;
   logic [AREA_W-1:0]  inter3_ff;
   logic [SUM_W-1:0]   uni3_ff;
   // Stage 4: threshold times union.
   logic               v4_ff, ok4_ff;
   logic [AREA_W-1:0]  inter4_ff;
   logic [MUL_W-1:0]   prod4_ff;

   logic [COORD_W-1:0] xl, yt, xr, yb;

   // Corners of the intersection rectangle.
   always_comb begin
      xl = (kept.box.left   > cand.left)   ? kept.box.left   : cand.left;
      yt = (kept.box.top    > cand.top)    ? kept.box.top    : cand.top;
      xr = (kept.box.right  < cand.right)  ? kept.box.right  : cand.right;
      yb = (kept.box.bottom < cand.bottom) ? kept.box.bottom : cand.bottom;
   end

   // Valid bits of the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      iw1_ff    <= span(xl, xr);
      ih1_ff    <= span(yt, yb);
      pos1_ff   <= (xr > xl) && (yb > yt);
      ak1_ff    <= kept.area;

      inter2_ff <= AREA_W'(iw1_ff) * AREA_W'(ih1_ff);
      sum2_ff   <= {1'b0, ak1_ff} + {1'b0, cand_area};
      pos2_ff   <= pos1_ff;

      inter3_ff <= inter2_ff;
      uni3_ff   <= sum2_ff - {1'b0, inter2_ff};
      ok3_ff    <= pos2_ff && (sum2_ff > {1'b0, inter2_ff});

      inter4_ff <= inter3_ff;
      prod4_ff  <= MUL_W'(thr) * MUL_W'(uni3_ff);
      ok4_ff    <= ok3_ff;
   end

   // Suppression when inter * 1.0 >= threshold * union.
   assign stat.hit  = v4_ff && ok4_ff &&
                      (MUL_W'({inter4_ff, {FRAC_W{1'b0}}}) >= prod4_ff);
   assign stat.busy = v1_ff || v2_ff || v3_ff || v4_ff;

endmodule

// ===== src/greedy_nms_per_class.sv =====
// Greedy per-class non-maximum suppression, top level and sequencer.
// Depends on gnms_pkg, gnms_store and gnms_iou.
//
// Usage: boxes of one class arrive on the req_ channel in descending score
// order, one box per beat, with req_list_end on the last one. Each box gets
// one rsp_ beat: kept (with its slot), suppressed, list full, or beyond the
// input cap. The kept list and the box count clear after the list_end beat.
// csr_wr_en writes the Q1.16 overlap threshold; write it only while idle.
//
// Flow: a box that is checked against K kept boxes (K at most MAX_KEEP) gives
// its result once the scan of those boxes ends, early on a hit, and the overlap
// pipeline drains; with an empty list no kept box is read. The kept boxes are
// read from one memory port and tested one per cycle by a single pipelined
// overlap unit that stops issuing at the first hit. req_ready is low while a
// box is in work, so the next box is taken as the result comes out. Boxes
// beyond the cap or past a full list skip the scan and go straight to the
// result. Reset clears the counters and the threshold to its default; the kept
// memory needs no clearing. The result sits in an output register, so a
// stalled receiver only holds the block at the next box's end.
`timescale 1ns / 1ps

module greedy_nms_per_class #(
   parameter int MAX_KEEP   = gnms_pkg::MAX_KEEP_DEF,
   parameter int MAX_INPUTS = gnms_pkg::MAX_INPUTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [gnms_pkg::COORD_W-1:0]       req_box_left,
   input  logic [gnms_pkg::COORD_W-1:0]       req_box_top,
   input  logic [gnms_pkg::COORD_W-1:0]       req_box_right,
   input  logic [gnms_pkg::COORD_W-1:0]       req_box_bottom,
   input  logic                               req_list_end,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [gnms_pkg::VERDICT_W-1:0]     rsp_verdict,
   output logic [gnms_pkg::SLOT_W-1:0]        rsp_kept_slot,
   output logic                               rsp_end_of_list,
   input  logic                               csr_wr_en,
   input  logic [gnms_pkg::THR_W-1:0]         csr_wr_data
);
   import gnms_pkg::*;

   localparam int KEEP_W = $clog2(MAX_KEEP + 1);
   localparam int SEEN_W = $clog2(MAX_INPUTS + 1);
   localparam int ADDR_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_AREA  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [THR_W-1:0]     thr_ff;
   logic [KEEP_W-1:0]    kept_total_ff, kept_total_in;
   logic [SEEN_W-1:0]    seen_total_ff, seen_total_in;
   logic [KEEP_W-1:0]    idx_ff, idx_in;
   logic                 hit_ff, hit_in;
   logic [VERDICT_W-1:0] verdict_ff, verdict_in;
   box_type              box_ff;
   logic                 last_ff;
   logic [AREA_W-1:0]    area_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VERDICT_W-1:0] rsp_verdict_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic                 rsp_last_ff;

   logic                 accept, issue, commit, rd_valid;
   entry_type            rd_data, wr_data;
   iou_stat_type         iou_stat;

   assign accept = req_valid && req_ready;
   assign issue  = (state_ff == ST_SCAN) && (idx_ff < kept_total_ff) &&
                   !hit_ff && !iou_stat.hit;
   assign commit = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign wr_data.box  = box_ff;
   assign wr_data.area = area_ff;

   gnms_store #(
      .DEPTH  (MAX_KEEP),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (commit && (verdict_ff == VERDICT_KEPT)),
      .wr_addr  (kept_total_ff[ADDR_W-1:0]),
      .wr_data  (wr_data),
      .rd_en    (issue),
      .rd_addr  (idx_ff[ADDR_W-1:0]),
      .rd_valid (rd_valid),
      .rd_data  (rd_data)
   );

   gnms_iou u_iou (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid),
      .kept      (rd_data),
      .cand      (box_ff),
      .cand_area (area_ff),
      .thr       (thr_ff),
      .stat      (iou_stat)
   );

   // Sequencer: classify, scan the kept list, then hand the result over.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      hit_in        = hit_ff || iou_stat.hit;
      verdict_in    = verdict_ff;
      kept_total_in = kept_total_ff;
      seen_total_in = seen_total_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = '0;
               hit_in = 1'b0;
               if (seen_total_ff >= SEEN_W'(MAX_INPUTS)) begin
                  verdict_in = VERDICT_CAP;
                  state_in   = ST_DONE;
               end else if (kept_total_ff >= KEEP_W'(MAX_KEEP)) begin
                  verdict_in = VERDICT_FULL;
                  state_in   = ST_DONE;
               end else begin
                  state_in = ST_AREA;
               end
            end
         end
         ST_AREA: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (issue) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid && !iou_stat.busy) begin
               verdict_in = hit_ff ? VERDICT_SUPP : VERDICT_KEPT;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (commit) begin
               state_in = ST_IDLE;
               if (verdict_ff == VERDICT_KEPT) begin
                  kept_total_in = kept_total_ff + 1'b1;
               end
               if (verdict_ff != VERDICT_CAP) begin
                  seen_total_in = seen_total_ff + 1'b1;
               end
               if (last_ff) begin
                  kept_total_in = '0;
                  seen_total_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         thr_ff        <= IOU_RESET;
         kept_total_ff <= '0;
         seen_total_ff <= '0;
         idx_ff        <= '0;
         hit_ff        <= 1'b0;
         verdict_ff    <= VERDICT_KEPT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         kept_total_ff <= kept_total_in;
         seen_total_ff <= seen_total_in;
         idx_ff        <= idx_in;
         hit_ff        <= hit_in;
         verdict_ff    <= verdict_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   // Candidate box, its area and the result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         box_ff.left   <= req_box_left;
         box_ff.top    <= req_box_top;
         box_ff.right  <= req_box_right;
         box_ff.bottom <= req_box_bottom;
         last_ff       <= req_list_end;
      end
      if (state_ff == ST_AREA) begin
         area_ff <= AREA_W'(span(box_ff.left, box_ff.right)) *
                    AREA_W'(span(box_ff.top, box_ff.bottom));
      end
      if (commit) begin
         rsp_verdict_ff <= verdict_ff;
         rsp_slot_ff    <= (verdict_ff == VERDICT_KEPT) ? SLOT_W'(kept_total_ff) : '0;
         rsp_last_ff    <= last_ff;
      end
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = rsp_verdict_ff;
   assign rsp_kept_slot   = rsp_slot_ff;
   assign rsp_end_of_list = rsp_last_ff;

   // The kept count never passes the list size.
   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      kept_total_ff <= KEEP_W'(MAX_KEEP))
      else $error("kept count exceeds the list size");

   // The examined count never passes the input cap.
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_total_ff <= SEEN_W'(MAX_INPUTS))
      else $error("examined count exceeds the input cap");

   // A suppressed box needs at least one kept box to overlap.
   a_supp_needs_kept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && verdict_ff == VERDICT_SUPP) |-> kept_total_ff != '0)
      else $error("box suppressed against an empty kept list");

   // A full-list verdict only appears when the list is full.
   a_full_verdict: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && verdict_ff == VERDICT_FULL) |->
         kept_total_ff == KEEP_W'(MAX_KEEP))
      else $error("full verdict with room left in the kept list");

endmodule
